// ----- sv/sdspi_pkg.sv -----
// shared types, codes and constants of the sd card spi host sequencer
package sdspi_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 512;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_XDONE = 3'd3,
    OP_DDONE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ACT_XCHG = 2'd0,
    ACT_TICK = 2'd1,
    ACT_DONE = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_PARAM = 3'd1, ST_NRDY = 3'd2, ST_XFER = 3'd3, ST_NOCARD = 3'd4
  } stat_t;

  typedef enum logic [1:0] {
    CFG_READY = 2'd0, CFG_RESP = 2'd1, CFG_INIT = 2'd2, CFG_TOKEN = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    P_IDLE, P_CLOCKS, P_CDESEL, P_CDUMMY, P_CREADY, P_CRDELAY, P_CSEND, P_CRESP,
    P_OCR, P_LDELAY, P_TOKEN, P_RDATA, P_RCRC, P_WTOKEN, P_WDATA, P_WCRC,
    P_WRESP, P_WBUSY, P_FDESEL
  } phase_t;

  typedef enum logic [2:0] {
    F_CMD0, F_CMD8, F_PROBE, F_LOOP, F_CMD58, F_CMD16, F_CMD17, F_CMD24
  } flow_t;

  // event kinds after classification
  typedef enum logic [1:0] {
    EV_INIT, EV_XFER, EV_XDONE, EV_DDONE
  } ev_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] sector;
    logic [15:0] block_count;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [3:0] card_kind;
  } out_beat_t;

  // classified event handed from front to back
  typedef struct packed {
    ev_t         ev;
    logic        wr;
    logic [31:0] sector;
    logic [15:0] block_count;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } evt_t;

  typedef struct packed {
    logic [15:0] ready_wait_limit;
    logic [7:0]  response_poll_limit;
    logic [15:0] init_poll_limit;
    logic [15:0] token_wait_limit;
  } cfg_t;

endpackage

// ----- sv/sd_card_spi_host_sequencer_unit.sv -----
// top level of the sd card spi host sequencer
// Drives an SD/MMC card in SPI mode one byte exchange at a time.
// Input channel (in_valid/in_ready, in_beat): requests (initialize, read,
// write) and events (exchange done with the received byte, delay done).
// Output channel (out_valid/out_ready, out_beat): one beat per request or
// expected event: the next byte to send with chip select, a wait of one
// 100 us tick, or completion with a status. Unexpected events give no beat.
// Configuration: write cfg_we with cfg_index/cfg_data while idle.
// Path: a beat enters a two-entry queue, the sequencer takes it from the queue
// and its result is registered in the output register.
// Throughput: one beat per cycle while the output register is free or draining.
// When the receiver stalls, the output register holds its beat and the
// queue absorbs up to two more beats before in_ready drops.
// Reset: card marked uninitialized, limits return to 5000, 10, 10000, 40000.
module sd_card_spi_host_sequencer_unit import sdspi_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  cfg_t cfg;
  logic ev_valid, ev_ready;
  evt_t ev_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_wait_limit <= 16'd5000;
      cfg.response_poll_limit <= 8'd10;
      cfg.init_poll_limit <= 16'd10000;
      cfg.token_wait_limit <= 16'd40000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_READY: cfg.ready_wait_limit <= cfg_data;
        CFG_RESP:  cfg.response_poll_limit <= cfg_data[7:0];
        CFG_INIT:  cfg.init_poll_limit <= cfg_data;
        default:   cfg.token_wait_limit <= cfg_data;
      endcase
    end
  end

  sdspi_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_beat,
    .ev_valid, .ev_ready, .ev_item
  );

  sdspi_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk, .rst, .cfg, .ev_valid, .ev_ready, .ev_item,
    .out_valid, .out_ready, .out_beat
  );

  // a stalled result beat must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("output beat changed while stalled");

  // non-exchange results never select the card
  a_cs_only_xchg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.action != ACT_XCHG |-> !out_beat.chip_select)
    else $error("chip select outside an exchange");

  // data beats only come with an exchange
  a_data_xchg: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.data_valid |-> out_beat.action == ACT_XCHG)
    else $error("data beat without exchange");
endmodule

// ----- sv/sdspi_front.sv -----
// front end: accepts input beats, classifies them and queues the known ones for the back end
module sdspi_front import sdspi_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  output logic     ev_valid,
  input  logic     ev_ready,
  output evt_t     ev_item
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  evt_t           mem [DEPTH];
  logic [AW-1:0]  wptr, rptr;
  logic [AW:0]    count;
  logic           push, pop, known;
  evt_t           cls;

  // classify the operation code
  always_comb begin
    cls = '0;
    cls.sector = in_beat.sector;
    cls.block_count = in_beat.block_count;
    cls.rx_byte = in_beat.rx_byte;
    cls.write_byte = in_beat.write_byte;
    known = 1'b1;
    unique case (in_beat.operation)
      OP_INIT:  cls.ev = EV_INIT;
      OP_READ:  cls.ev = EV_XFER;
      OP_WRITE: begin
        cls.ev = EV_XFER;
        cls.wr = 1'b1;
      end
      OP_XDONE: cls.ev = EV_XDONE;
      OP_DDONE: cls.ev = EV_DDONE;
      default:  known = 1'b0;
    endcase
  end

  assign in_ready = (count != DEPTH[AW:0]);
  assign push = in_valid && in_ready && known;
  assign ev_valid = (count != '0);
  assign pop = ev_valid && ev_ready;
  assign ev_item = mem[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
    end
  end
endmodule

// ----- sv/sdspi_back.sv -----
// back end: card sequencing state machine with registered result
module sdspi_back import sdspi_pkg::*; #(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      ev_valid,
  output logic      ev_ready,
  input  evt_t      ev_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);
  localparam int unsigned BW = $clog2(BLOCK_BYTES) + 1;

  phase_t      phase, phase_next;
  flow_t       flow, flow_next;
  logic [3:0]  card_type, card_type_next;
  logic        uninitialized, uninitialized_next;
  logic [15:0] wait_counter, wait_counter_next;
  logic [7:0]  response_counter, response_counter_next;
  logic [BW-1:0] byte_index, byte_index_next;
  logic [31:0] card_address, card_address_next;
  logic [15:0] blocks_left, blocks_left_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [31:0] command_argument, command_argument_next;
  logic [7:0]  ocr_bytes [4];
  logic        ocr_we;
  logic [3:0]  kind, kind_next;
  logic [1:0]  awaiting, awaiting_next;
  logic        prefix, prefix_next, writing, writing_next;
  logic        after_next, after_next_next;
  logic [2:0]  final_status, final_status_next;
  logic [15:0] loop_counter, loop_counter_next;

  out_beat_t   res;
  logic        emit, take;

  // one event is taken whenever the output register is free or draining
  assign take = ev_valid && (!out_valid || out_ready);
  assign ev_ready = !out_valid || out_ready;

  function automatic logic [7:0] frame_byte(input logic pf, input logic [7:0] cb,
                                            input logic [31:0] arg,
                                            input logic [BW-1:0] i);
    logic [7:0]  c;
    logic [31:0] a;
    c = pf ? 8'h77 : {1'b0, cb[6:0]};
    a = pf ? 32'd0 : arg;
    if (i == '0) return c;
    if (i == BW'(1)) return a[31:24];
    if (i == BW'(2)) return a[23:16];
    if (i == BW'(3)) return a[15:8];
    if (i == BW'(4)) return a[7:0];
    if (c == 8'h40) return 8'h95;
    if (c == 8'h48) return 8'h87;
    return 8'h01;
  endfunction

  // next state and result
  always_comb begin
    logic [7:0]  rx;
    logic [7:0]  r;
    logic        do_cmd_done, do_raw, do_loop, do_init_end, do_start, do_end;
    logic        do_block_end, do_next_block;
    flow_t       sf;
    logic [7:0]  sc;
    logic [31:0] sa;
    logic [3:0]  ity;
    logic [2:0]  est;
    logic        enx;
    logic [15:0] wc;
    logic [7:0]  rc;
    logic [BW-1:0] bi;
    phase_next = phase; flow_next = flow; card_type_next = card_type;
    uninitialized_next = uninitialized; wait_counter_next = wait_counter;
    response_counter_next = response_counter; byte_index_next = byte_index;
    card_address_next = card_address; blocks_left_next = blocks_left;
    command_byte_next = command_byte; command_argument_next = command_argument;
    kind_next = kind; awaiting_next = awaiting; prefix_next = prefix;
    writing_next = writing; after_next_next = after_next;
    final_status_next = final_status; loop_counter_next = loop_counter;
    ocr_we = 1'b0;
    res = '0; emit = 1'b0;
    rx = ev_item.rx_byte; r = 8'h00;
    do_cmd_done = 1'b0; do_raw = 1'b0; do_loop = 1'b0; do_init_end = 1'b0;
    do_start = 1'b0; do_end = 1'b0; do_block_end = 1'b0; do_next_block = 1'b0;
    sf = F_CMD0; sc = 8'h00; sa = 32'd0; ity = 4'd0; est = ST_OK; enx = 1'b0;
    wc = wait_counter + 16'd1;
    rc = response_counter + 8'd1;
    bi = byte_index + BW'(1);

    if (take) begin
      unique case (ev_item.ev)
        EV_INIT: begin
          kind_next = '0; byte_index_next = '0;
          emit = 1'b1; res.tx_byte = 8'hFF; phase_next = P_CLOCKS; awaiting_next = 2'd1;
        end
        EV_XFER: begin
          emit = 1'b1;
          if (ev_item.block_count == '0) begin
            res.action = ACT_DONE; res.status = ST_PARAM;
            phase_next = P_IDLE; awaiting_next = 2'd0;
          end else if (uninitialized) begin
            res.action = ACT_DONE; res.status = ST_NRDY;
            phase_next = P_IDLE; awaiting_next = 2'd0;
          end else begin
            card_address_next = card_type[3] ? ev_item.sector
                                             : {ev_item.sector[22:0], 9'd0};
            blocks_left_next = ev_item.block_count;
            writing_next = ev_item.wr;
            do_next_block = 1'b1;
          end
        end
        EV_DDONE: begin
          if (awaiting == 2'd2) begin
            emit = 1'b1;
            if (phase == P_CRDELAY) begin
              res.tx_byte = 8'hFF; res.chip_select = 1'b1;
              phase_next = P_CREADY; awaiting_next = 2'd1;
            end else begin
              loop_counter_next = loop_counter - 16'd1;
              do_loop = 1'b1;
            end
          end
        end
        default: begin
          if (awaiting == 2'd1) begin
            emit = 1'b1;
            unique case (phase)
              P_CLOCKS: begin
                byte_index_next = bi;
                if (bi < BW'(10)) begin
                  res.tx_byte = 8'hFF; awaiting_next = 2'd1;
                end else begin
                  do_start = 1'b1; sf = F_CMD0; sc = 8'h40; sa = '0;
                end
              end
              P_CDESEL: begin
                wait_counter_next = '0;
                res.tx_byte = 8'hFF; res.chip_select = 1'b1; phase_next = P_CDUMMY;
              end
              P_CDUMMY: begin
                if (cfg.ready_wait_limit == '0) begin
                  do_raw = 1'b1; r = 8'hFF;
                end else begin
                  res.tx_byte = 8'hFF; res.chip_select = 1'b1; phase_next = P_CREADY;
                end
              end
              P_CREADY: begin
                if (rx == 8'hFF) begin
                  byte_index_next = '0;
                  res.tx_byte = frame_byte(prefix, command_byte, command_argument, '0);
                  res.chip_select = 1'b1; phase_next = P_CSEND;
                end else begin
                  wait_counter_next = wc;
                  if (wc >= cfg.ready_wait_limit) begin
                    do_raw = 1'b1; r = 8'hFF;
                  end else begin
                    res.action = ACT_TICK; phase_next = P_CRDELAY; awaiting_next = 2'd2;
                  end
                end
              end
              P_CSEND: begin
                byte_index_next = bi;
                res.chip_select = 1'b1;
                if (bi < BW'(6)) begin
                  res.tx_byte = frame_byte(prefix, command_byte, command_argument, bi);
                end else begin
                  response_counter_next = '0;
                  res.tx_byte = 8'hFF; phase_next = P_CRESP;
                end
              end
              P_CRESP: begin
                response_counter_next = rc;
                if (rx[7] && rc < cfg.response_poll_limit) begin
                  res.tx_byte = 8'hFF; res.chip_select = 1'b1;
                end else begin
                  do_raw = 1'b1; r = rx;
                end
              end
              P_OCR: begin
                ocr_we = 1'b1;
                byte_index_next = bi;
                if (bi < BW'(4)) begin
                  res.tx_byte = 8'hFF; res.chip_select = 1'b1;
                end else if (flow == F_CMD58) begin
                  do_init_end = 1'b1;
                  ity = ocr_bytes[0][6] ? 4'hC : 4'h4;
                end else if (ocr_bytes[2] == 8'h01 && rx == 8'hAA) begin
                  kind_next = 4'h4; loop_counter_next = cfg.init_poll_limit;
                  do_loop = 1'b1;
                end else begin
                  do_init_end = 1'b1; ity = '0;
                end
              end
              P_TOKEN: begin
                wait_counter_next = wc;
                if (rx == 8'hFF && wc < cfg.token_wait_limit) begin
                  res.tx_byte = 8'hFF; res.chip_select = 1'b1;
                end else if (rx != 8'hFE) begin
                  do_end = 1'b1; est = ST_XFER;
                end else begin
                  byte_index_next = '0;
                  res.tx_byte = 8'hFF; res.chip_select = 1'b1; phase_next = P_RDATA;
                end
              end
              P_RDATA: begin
                res.data_valid = 1'b1; res.data_byte = rx;
                res.tx_byte = 8'hFF; res.chip_select = 1'b1;
                if (bi < BW'(BLOCK_BYTES)) begin
                  byte_index_next = bi;
                end else begin
                  byte_index_next = '0; phase_next = P_RCRC;
                end
              end
              P_RCRC: begin
                byte_index_next = bi;
                if (bi < BW'(2)) begin
                  res.tx_byte = 8'hFF; res.chip_select = 1'b1;
                end else begin
                  do_block_end = 1'b1;
                end
              end
              P_WTOKEN: begin
                byte_index_next = '0;
                res.tx_byte = ev_item.write_byte; res.chip_select = 1'b1;
                phase_next = P_WDATA;
              end
              P_WDATA: begin
                res.chip_select = 1'b1;
                if (bi < BW'(BLOCK_BYTES)) begin
                  byte_index_next = bi; res.tx_byte = ev_item.write_byte;
                end else begin
                  byte_index_next = '0; res.tx_byte = 8'hFF; phase_next = P_WCRC;
                end
              end
              P_WCRC: begin
                byte_index_next = bi;
                res.tx_byte = 8'hFF; res.chip_select = 1'b1;
                if (bi >= BW'(2)) phase_next = P_WRESP;
              end
              P_WRESP: begin
                if (rx[4:0] != 5'h05) begin
                  do_end = 1'b1; est = ST_XFER;
                end else begin
                  res.tx_byte = 8'hFF; res.chip_select = 1'b1; phase_next = P_WBUSY;
                end
              end
              P_WBUSY: begin
                if (rx == 8'h00) begin
                  res.tx_byte = 8'hFF; res.chip_select = 1'b1;
                end else begin
                  do_block_end = 1'b1;
                end
              end
              P_FDESEL: begin
                if (after_next) begin
                  do_next_block = 1'b1;
                end else begin
                  res.action = ACT_DONE; res.status = final_status;
                  phase_next = P_IDLE; awaiting_next = 2'd0;
                end
              end
              default: emit = 1'b0;
            endcase
          end
        end
      endcase

      // command response with prefix handling
      if (do_raw) begin
        if (prefix) begin
          prefix_next = 1'b0;
          if (r > 8'd1) begin
            do_cmd_done = 1'b1;
          end else begin
            res.tx_byte = 8'hFF; res.chip_select = 1'b0; phase_next = P_CDESEL;
          end
        end else begin
          do_cmd_done = 1'b1;
        end
      end

      if (do_cmd_done) begin
        unique case (flow)
          F_CMD0: begin
            if (r == 8'd1) begin
              do_start = 1'b1; sf = F_CMD8; sc = 8'h48; sa = 32'h1AA;
            end else begin
              do_init_end = 1'b1; ity = '0;
            end
          end
          F_CMD8: begin
            if (r == 8'd1) begin
              byte_index_next = '0;
              res.tx_byte = 8'hFF; res.chip_select = 1'b1; phase_next = P_OCR;
            end else begin
              do_start = 1'b1; sf = F_PROBE; sc = 8'hE9; sa = '0;
            end
          end
          F_PROBE: begin
            kind_next = (r <= 8'd1) ? 4'h2 : 4'h1;
            loop_counter_next = cfg.init_poll_limit;
            do_loop = 1'b1;
          end
          F_LOOP: begin
            if (r != 8'd0) begin
              res.action = ACT_TICK; phase_next = P_LDELAY; awaiting_next = 2'd2;
            end else if (kind == 4'h4) begin
              do_start = 1'b1; sf = F_CMD58; sc = 8'h7A; sa = '0;
            end else begin
              do_start = 1'b1; sf = F_CMD16; sc = 8'h50; sa = 32'd512;
            end
          end
          F_CMD58: begin
            if (r == 8'd0) begin
              byte_index_next = '0;
              res.tx_byte = 8'hFF; res.chip_select = 1'b1; phase_next = P_OCR;
            end else begin
              do_init_end = 1'b1; ity = '0;
            end
          end
          F_CMD16: begin
            do_init_end = 1'b1; ity = (r == 8'd0) ? kind : 4'd0;
          end
          F_CMD17: begin
            if (r != 8'd0) begin
              do_end = 1'b1; est = ST_XFER;
            end else begin
              wait_counter_next = '0;
              res.tx_byte = 8'hFF; res.chip_select = 1'b1; phase_next = P_TOKEN;
            end
          end
          default: begin
            if (r != 8'd0) begin
              do_end = 1'b1; est = ST_XFER;
            end else begin
              res.tx_byte = 8'hFE; res.chip_select = 1'b1; phase_next = P_WTOKEN;
            end
          end
        endcase
      end

      // init loop step, kind from updated value
      if (do_loop) begin
        if (loop_counter_next == '0) begin
          do_init_end = 1'b1; ity = '0;
        end else begin
          do_start = 1'b1; sf = F_LOOP;
          sc = (kind_next == 4'h1) ? 8'h41 : 8'hE9;
          sa = (kind_next == 4'h4) ? 32'h4000_0000 : 32'd0;
        end
      end

      if (do_block_end) begin
        card_address_next = card_address + (card_type[3] ? 32'd1 : 32'(BLOCK_BYTES));
        blocks_left_next = blocks_left - 16'd1;
        do_end = 1'b1; est = ST_OK; enx = (blocks_left_next != '0);
      end

      if (do_next_block) begin
        do_start = 1'b1;
        sf = writing_next ? F_CMD24 : F_CMD17;
        sc = writing_next ? 8'h58 : 8'h51;
        sa = card_address_next;
      end

      if (do_init_end) begin
        card_type_next = ity;
        uninitialized_next = (ity == '0);
        do_end = 1'b1; est = (ity != '0) ? ST_OK : ST_NOCARD; enx = 1'b0;
      end

      if (do_end) begin
        final_status_next = est; after_next_next = enx;
        res.action = ACT_XCHG; res.tx_byte = 8'hFF; res.chip_select = 1'b0;
        phase_next = P_FDESEL; awaiting_next = 2'd1;
      end

      if (do_start) begin
        flow_next = sf; command_byte_next = sc; command_argument_next = sa;
        prefix_next = sc[7];
        res.action = ACT_XCHG; res.tx_byte = 8'hFF; res.chip_select = 1'b0;
        phase_next = P_CDESEL; awaiting_next = 2'd1;
      end

      if (emit && res.action == ACT_XCHG && phase_next != P_IDLE &&
          !(phase_next == P_CRDELAY || phase_next == P_LDELAY)) begin
        awaiting_next = 2'd1;
      end
      if (res.action != ACT_XCHG) begin
        res.tx_byte = '0; res.chip_select = 1'b0;
      end
      res.card_kind = card_type_next;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE; flow <= F_CMD0; card_type <= '0; uninitialized <= 1'b1;
      wait_counter <= '0; response_counter <= '0; byte_index <= '0;
      card_address <= '0; blocks_left <= '0; command_byte <= '0;
      command_argument <= '0; kind <= '0; awaiting <= '0; prefix <= 1'b0;
      writing <= 1'b0; after_next <= 1'b0; final_status <= '0; loop_counter <= '0;
    end else begin
      phase <= phase_next; flow <= flow_next; card_type <= card_type_next;
      uninitialized <= uninitialized_next; wait_counter <= wait_counter_next;
      response_counter <= response_counter_next; byte_index <= byte_index_next;
      card_address <= card_address_next; blocks_left <= blocks_left_next;
      command_byte <= command_byte_next; command_argument <= command_argument_next;
      kind <= kind_next; awaiting <= awaiting_next; prefix <= prefix_next;
      writing <= writing_next; after_next <= after_next_next;
      final_status <= final_status_next; loop_counter <= loop_counter_next;
    end
  end

  // ocr capture
  always_ff @(posedge clk) begin
    if (ocr_we) ocr_bytes[byte_index[1:0]] <= ev_item.rx_byte;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) out_beat <= res;
  end
endmodule
